[sv/lcsl_pkg.sv]
// shared constants for the longest common substring length core
// no dependencies; imported by the interfaces and the core top level, not by lcsl_ram
`default_nettype none

package lcsl_pkg;

  // capacity of the first-string store and the run column
  localparam int MAX_LEN = 1024;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  // first-string length counter must hold MAX_LEN itself
  localparam int LEN_W   = $clog2(MAX_LEN + 1);

  localparam int SYM_W   = 8;
  localparam int RUN_W   = 11;
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  // item commands
  localparam logic CMD_FIRST  = 1'b0;
  localparam logic CMD_SECOND = 1'b1;

endpackage

`default_nettype wire

[sv/lcsl_item_if.sv]
// input channel: valid/ready handshake carrying one character item
// depends on lcsl_pkg for the symbol width
`default_nettype none

interface lcsl_item_if
  import lcsl_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [SYM_W-1:0] symbol;
  logic             final_char;

  modport source (output valid, output cmd, output symbol, output final_char, input ready);
  modport sink   (input valid, input cmd, input symbol, input final_char, output ready);
endinterface

`default_nettype wire

[sv/lcsl_result_if.sv]
// output channel: valid/ready handshake carrying one result item
// depends on lcsl_pkg for the run length width
`default_nettype none

interface lcsl_result_if
  import lcsl_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [RUN_W-1:0] longest;
  logic             overflow;

  modport source (output valid, output longest, output overflow, input ready);
  modport sink   (input valid, input longest, input overflow, output ready);
endinterface

`default_nettype wire

[sv/longest_common_substring_length_core.sv]
// top level of the longest common substring length core
// depends on lcsl_pkg, lcsl_item_if, lcsl_result_if and lcsl_ram
`default_nettype none

// Measures the longest common substring of two byte strings. Send the first
// string as cmd=0 items (no result); bytes past MAX_LEN are dropped and
// flagged as overflow. Then send the second string as cmd=1 items; the one
// carrying final_char returns the best length and the overflow flag, and the
// core starts afresh. Each second-string item sweeps the stored run column,
// one entry per cycle through the two block rams, from the last stored
// first-string byte down to the first. The run column needs no clearing pass
// after reset: an entry is zeroed as its first-string byte is stored, and only
// stored positions are ever used. A result waiting at the output does not
// hold up the next string, only the next result.
module longest_common_substring_length_core
  import lcsl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  lcsl_item_if.sink     item,
  lcsl_result_if.source result
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state;
  logic [LEN_W-1:0]  first_length;
  logic [RUN_W-1:0]  best;
  logic              overflow_seen;
  logic [SYM_W-1:0]  sym;
  logic              fin;
  logic [ADDR_W-1:0] k;
  logic              p_valid;
  logic [ADDR_W-1:0] p_k;
  logic              p_first;
  logic              res_valid;
  logic [RUN_W-1:0]  res_longest;
  logic              res_overflow;

  logic              item_fire;
  logic              has_room;
  logic              append_we;
  logic              emit;
  logic [SYM_W-1:0]  store_rd;
  logic [RUN_W-1:0]  run_rd;
  logic              run_we;
  logic [ADDR_W-1:0] run_waddr;
  logic [RUN_W-1:0]  run_wdata;
  logic [RUN_W-1:0]  diag;
  logic              match;
  logic [RUN_W-1:0]  new_run;

  assign item.ready   = (state == ST_IDLE);
  assign item_fire    = item.valid && item.ready;
  assign has_room     = first_length < LEN_W'(MAX_LEN);
  assign append_we    = item_fire && (item.cmd == CMD_FIRST) && has_room;

  assign result.valid    = res_valid;
  assign result.longest  = res_longest;
  assign result.overflow = res_overflow;

  assign emit = (state == ST_DONE) && fin && (!res_valid || result.ready);

  // diagonal entry is the previous row's value one position lower
  assign match   = (store_rd == sym);
  assign diag    = p_first ? '0 : run_rd;
  assign new_run = !match ? '0 : ((diag == RUN_MAX) ? diag : diag + RUN_W'(1));

  // sweep writes and appends never coincide: appends happen only when idle
  assign run_we    = p_valid || append_we;
  assign run_waddr = p_valid ? p_k : first_length[ADDR_W-1:0];
  assign run_wdata = p_valid ? new_run : '0;

  lcsl_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk     (clk),
    .wr_en   (append_we),
    .wr_addr (first_length[ADDR_W-1:0]),
    .wr_data (item.symbol),
    .rd_addr (k),
    .rd_data (store_rd)
  );

  // read one below the sweep position; wraps at zero where the value is unused
  lcsl_ram #(
    .WIDTH (RUN_W),
    .DEPTH (MAX_LEN)
  ) u_run (
    .clk     (clk),
    .wr_en   (run_we),
    .wr_addr (run_waddr),
    .wr_data (run_wdata),
    .rd_addr (k - ADDR_W'(1)),
    .rd_data (run_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      first_length  <= '0;
      best          <= '0;
      overflow_seen <= 1'b0;
      p_valid       <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      p_valid <= (state == ST_SWEEP);
      if (p_valid && (new_run > best)) begin
        best <= new_run;
      end
      if (res_valid && result.ready && !emit) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_fire) begin
            if (item.cmd == CMD_FIRST) begin
              if (has_room) begin
                first_length <= first_length + LEN_W'(1);
              end else begin
                overflow_seen <= 1'b1;
              end
            end else if (first_length != '0) begin
              state <= ST_SWEEP;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SWEEP: begin
          if (k == '0) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!fin) begin
            state <= ST_IDLE;
          end else if (emit) begin
            res_valid     <= 1'b1;
            first_length  <= '0;
            best          <= '0;
            overflow_seen <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    p_k     <= k;
    p_first <= (k == '0);
    if (item_fire) begin
      sym <= item.symbol;
      fin <= item.final_char;
      k   <= ADDR_W'(first_length - LEN_W'(1));
    end else if (state == ST_SWEEP) begin
      k <= k - ADDR_W'(1);
    end
    if (emit) begin
      res_longest  <= best;
      res_overflow <= overflow_seen;
    end
  end

endmodule

`default_nettype wire

[sv/lcsl_ram.sv]
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`default_nettype none

module lcsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[tb/lcsl_tb_pkg.sv]
`timescale 1ns / 1ps
// scoreboard for the longest common substring length core: predicts each result
// from the accepted characters and checks the results that come back
// depends on lcsl_pkg for widths, capacity and item commands

package lcsl_tb_pkg;
  import lcsl_pkg::*;

  class lcs_scoreboard;
    typedef struct packed {
      logic [RUN_W-1:0] longest;
      logic             overflow;
    } lcs_result_t;

    logic [SYM_W-1:0] first_str [MAX_LEN];
    logic [RUN_W-1:0] run_len [MAX_LEN];
    int               first_len;
    logic [RUN_W-1:0] best_len;
    logic             truncated;
    lcs_result_t      expected_results [$];
    int               errors;

    function new();
      errors = 0;
      clear();
    endfunction

    // run entries need no clearing, each is zeroed as its byte is stored
    function void clear();
      first_len = 0;
      best_len  = '0;
      truncated = 1'b0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // called for every accepted character transfer
    function void note_item(logic cmd, logic [SYM_W-1:0] sym, logic fin);
      lcs_result_t res;
      logic [RUN_W:0] run;
      int k;
      if (cmd == CMD_FIRST) begin
        if (first_len < MAX_LEN) begin
          first_str[first_len] = sym;
          run_len[first_len]   = '0;
          first_len++;
        end else begin
          truncated = 1'b1;
        end
        return;
      end
      // sweep downwards so the diagonal entry still holds the previous row
      for (k = first_len - 1; k >= 0; k--) begin
        if (first_str[k] == sym) begin
          run = (k == 0) ? (RUN_W+1)'(1) : {1'b0, run_len[k-1]} + (RUN_W+1)'(1);
          if (run > {1'b0, RUN_MAX}) run = {1'b0, RUN_MAX};
          run_len[k] = run[RUN_W-1:0];
          if (run_len[k] > best_len) best_len = run_len[k];
        end else begin
          run_len[k] = '0;
        end
      end
      if (fin) begin
        res.longest  = best_len;
        res.overflow = truncated;
        expected_results.push_back(res);
        clear();
      end
    endfunction

    function void check_result(logic [RUN_W-1:0] longest, logic overflow);
      lcs_result_t exp_res;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual longest %0d overflow %0d",
                 $time, longest, overflow);
        errors++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (longest !== exp_res.longest) begin
        $display("%0t: longest mismatch, expected %0d, actual %0d",
                 $time, exp_res.longest, longest);
        errors++;
      end
      if (overflow !== exp_res.overflow) begin
        $display("%0t: overflow mismatch, expected %0d, actual %0d",
                 $time, exp_res.overflow, overflow);
        errors++;
      end
    endfunction
  endclass

endpackage

[tb/tb_longest_common_substring_length_core.sv]
`timescale 1ns / 1ps
// testbench top for longest_common_substring_length_core: directed strings,
// then random string pairs with noise and random stalls
// depends on lcsl_pkg, lcsl_item_if, lcsl_result_if and lcsl_tb_pkg

module tb_longest_common_substring_length_core;
  import lcsl_pkg::*;
  import lcsl_tb_pkg::*;

  localparam int IDLE_LIMIT   = 20000;
  localparam int TAIL_CYCLES  = 1100;
  localparam int RANDOM_ITEMS = 560;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   steady = 1'b0;
  int   items_sent = 0;
  int   idle_cycles = 0;

  lcsl_item_if   item_ch ();
  lcsl_result_if res_ch ();

  lcs_scoreboard sb = new();

  longest_common_substring_length_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch)
  );

  always #5 clk = ~clk;

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(10, 80);
  endfunction

  task automatic send_item(input logic c, input logic [SYM_W-1:0] s, input logic f);
    int n;
    n = steady ? 0 : pick_gap();
    @(negedge clk);
    if (n > 0) begin
      item_ch.valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    item_ch.valid      = 1'b1;
    item_ch.cmd        = c;
    item_ch.symbol     = s;
    item_ch.final_char = f;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_item(c, s, f);
    items_sent++;
  endtask

  // hold off the sender until every predicted result has come back
  task automatic drain();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int n;
    res_ch.ready = 1'b0;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        res_ch.ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      res_ch.ready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.longest, res_ch.overflow);
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int i, n, flen, slen, offset, base, span, first_count;
    logic [SYM_W-1:0] text [$];
    logic [SYM_W-1:0] ch;
    item_ch.valid      = 1'b0;
    item_ch.cmd        = CMD_FIRST;
    item_ch.symbol     = '0;
    item_ch.final_char = 1'b0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty first string gives zero
    send_item(CMD_SECOND, 8'h00, 1'b1);
    // byte extremes
    send_item(CMD_FIRST, 8'h00, 1'b0);
    send_item(CMD_FIRST, 8'hff, 1'b0);
    send_item(CMD_SECOND, 8'hff, 1'b1);
    // alternating bit patterns, full match of two
    send_item(CMD_FIRST, 8'h55, 1'b0);
    send_item(CMD_FIRST, 8'haa, 1'b0);
    send_item(CMD_SECOND, 8'h55, 1'b0);
    send_item(CMD_SECOND, 8'haa, 1'b1);
    // final mark on a first-string byte is ignored
    send_item(CMD_FIRST, 8'h12, 1'b1);
    send_item(CMD_FIRST, 8'h34, 1'b0);
    send_item(CMD_SECOND, 8'h12, 1'b0);
    send_item(CMD_SECOND, 8'h34, 1'b1);
    // first-string byte appended after second-string bytes
    send_item(CMD_FIRST, 8'h01, 1'b0);
    send_item(CMD_SECOND, 8'h01, 1'b0);
    send_item(CMD_FIRST, 8'h02, 1'b0);
    send_item(CMD_SECOND, 8'h02, 1'b1);
    // nothing matches
    send_item(CMD_FIRST, 8'h80, 1'b0);
    send_item(CMD_SECOND, 8'h7f, 1'b1);
    drain();

    first_count = items_sent;
    while (items_sent - first_count < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      base   = $urandom_range(0, 255);
      span   = ($urandom_range(0, 2) == 0) ? 256 : $urandom_range(1, 4);
      if ($urandom_range(0, 99) < 85) begin
        flen = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
        slen = $urandom_range(1, 10);
        text.delete();
        for (i = 0; i < flen; i++) begin
          ch = 8'(base + $urandom_range(0, span - 1));
          text.push_back(ch);
          send_item(CMD_FIRST, ch, $urandom_range(0, 9) == 0);
        end
        // second string partly copied from the first to build long runs
        offset = (flen > 0) ? $urandom_range(0, flen - 1) : 0;
        for (i = 0; i < slen; i++) begin
          if (flen > 0 && $urandom_range(0, 1) == 1) ch = text[(offset + i) % flen];
          else ch = 8'(base + $urandom_range(0, span - 1));
          send_item(CMD_SECOND, ch, i == slen - 1);
        end
      end else begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    $urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 49) == 0) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[longest_common_substring_length_core.f]
sv/lcsl_pkg.sv
sv/lcsl_item_if.sv
sv/lcsl_result_if.sv
sv/lcsl_ram.sv
sv/longest_common_substring_length_core.sv
tb/lcsl_tb_pkg.sv
tb/tb_longest_common_substring_length_core.sv
